// ----- src/eas_pkg.sv -----
// shared types, codes and helpers for the edge avoid seek drive controller
package eas_pkg;

  // drive level codes
  localparam logic [1:0] DRV_STOP     = 2'd0;
  localparam logic [1:0] DRV_MED_FWD  = 2'd1;
  localparam logic [1:0] DRV_FAST_FWD = 2'd2;
  localparam logic [1:0] DRV_MED_REV  = 2'd3;

  // mode codes as they appear on the result beat
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_RUN     = 2'd1;
  localparam logic [1:0] MODE_ATTACK  = 2'd2;
  localparam logic [1:0] MODE_BACKOFF = 2'd3;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] REG_EDGE_THRESHOLD   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_STEER_MIN_DIFF   = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_START_WAIT_TICKS = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_BACKOFF_TICKS    = 8'd3;

  // configuration reset values
  localparam logic [7:0] EDGE_THRESHOLD_RST   = 8'h30;
  localparam logic [7:0] STEER_MIN_DIFF_RST   = 8'h04;
  localparam logic [7:0] START_WAIT_TICKS_RST = 8'd250;
  localparam logic [7:0] BACKOFF_TICKS_RST    = 8'd75;

  // control state reset values
  localparam logic [7:0] DELAY_COUNT_RST = 8'd10;
  localparam logic [7:0] START_COUNT_RST = 8'd0;

  // controller state, one-hot
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_RUN     = 4'b0010,
    ST_ATTACK  = 4'b0100,
    ST_BACKOFF = 4'b1000
  } mode_state_t;

  typedef struct packed {
    logic [0:0] tick;
    logic [7:0] line_left;
    logic [7:0] line_center;
    logic [7:0] line_right;
    logic [7:0] range_front_left;
    logic [7:0] range_front_right;
  } eas_in_t;

  typedef struct packed {
    logic [0:0] motor_update;
    logic [1:0] left_drive;
    logic [1:0] right_drive;
    logic [1:0] mode;
  } eas_out_t;

  typedef struct packed {
    logic [7:0] edge_threshold;
    logic [7:0] steer_min_diff;
    logic [7:0] start_wait_ticks;
    logic [7:0] backoff_ticks;
  } eas_cfg_t;

  typedef struct packed {
    mode_state_t mode;
    logic [7:0]  delay_count;
    logic [7:0]  start_count;
  } eas_state_t;

  // one-hot state to result mode code
  function automatic logic [1:0] mode_code(input mode_state_t st);
    logic [1:0] code;
    unique case (st)
      ST_IDLE:    code = MODE_IDLE;
      ST_RUN:     code = MODE_RUN;
      ST_ATTACK:  code = MODE_ATTACK;
      ST_BACKOFF: code = MODE_BACKOFF;
      default:    code = MODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ----- src/eas_cfg_regs.sv -----
// configuration register file with write decode
module eas_cfg_regs
  import eas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data,
  output eas_cfg_t           cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register write, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_threshold   <= EDGE_THRESHOLD_RST;
      cfg.steer_min_diff   <= STEER_MIN_DIFF_RST;
      cfg.start_wait_ticks <= START_WAIT_TICKS_RST;
      cfg.backoff_ticks    <= BACKOFF_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EDGE_THRESHOLD:   cfg.edge_threshold   <= cfg_data;
        REG_STEER_MIN_DIFF:   cfg.steer_min_diff   <= cfg_data;
        REG_START_WAIT_TICKS: cfg.start_wait_ticks <= cfg_data;
        REG_BACKOFF_TICKS:    cfg.backoff_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/eas_step.sv -----
// one tick of the drive controller: next state and result beat
module eas_step
  import eas_pkg::*;
(
  input  eas_in_t    item,
  input  eas_cfg_t   cfg,
  input  eas_state_t state,
  output eas_state_t state_next,
  output eas_out_t   result
);

  logic        edge_seen;
  logic        go_back;
  mode_state_t mode_eff;
  logic [7:0]  delay_eff;
  logic [7:0]  delay_dec;
  logic [7:0]  start_inc;
  logic        target_right;
  logic [7:0]  range_diff;
  logic        upd;
  logic [1:0]  ld;
  logic [1:0]  rd;

  // edge barrier on any line sensor
  assign edge_seen = (item.line_left > cfg.edge_threshold) ||
                     (item.line_center > cfg.edge_threshold) ||
                     (item.line_right > cfg.edge_threshold);
  assign go_back   = edge_seen && ((state.mode == ST_RUN) || (state.mode == ST_ATTACK));
  assign mode_eff  = go_back ? ST_BACKOFF : state.mode;
  assign delay_eff = go_back ? cfg.backoff_ticks : state.delay_count;
  assign delay_dec = delay_eff - 8'd1;
  assign start_inc = state.start_count + 8'd1;

  // steering direction and magnitude
  assign target_right = item.range_front_right > item.range_front_left;
  assign range_diff   = target_right ? (item.range_front_right - item.range_front_left)
                                     : (item.range_front_left - item.range_front_right);

  // mode logic
  always_comb begin
    state_next = state;
    upd        = 1'b0;
    ld         = DRV_STOP;
    rd         = DRV_STOP;
    if (item.tick == 1'b1) begin
      state_next.mode        = mode_eff;
      state_next.delay_count = delay_eff;
      unique case (mode_eff)
        ST_IDLE: begin
          if (start_inc > cfg.start_wait_ticks) begin
            state_next.start_count = 8'd0;
            state_next.mode        = ST_RUN;
          end else begin
            state_next.start_count = start_inc;
          end
        end
        ST_RUN, ST_ATTACK: begin
          state_next.delay_count = delay_dec;
          if (delay_dec == 8'd0) begin
            state_next.delay_count = 8'd1;
            upd = 1'b1;
            if (range_diff < cfg.steer_min_diff) begin
              ld = DRV_MED_FWD;
              rd = DRV_MED_FWD;
              state_next.mode = ST_RUN;
            end else begin
              ld = target_right ? DRV_FAST_FWD : DRV_MED_FWD;
              rd = target_right ? DRV_MED_FWD : DRV_FAST_FWD;
              state_next.mode = ST_ATTACK;
            end
          end
        end
        ST_BACKOFF: begin
          // turn away on the first backoff tick
          if (delay_eff == cfg.backoff_ticks) begin
            upd = 1'b1;
            if (item.line_right > cfg.edge_threshold) begin
              ld = DRV_MED_FWD;
              rd = DRV_MED_REV;
            end else begin
              ld = DRV_MED_REV;
              rd = DRV_MED_FWD;
            end
          end
          state_next.delay_count = delay_dec;
          // turn done, resume run
          if (delay_dec == 8'd0) begin
            upd = 1'b1;
            ld  = DRV_MED_FWD;
            rd  = DRV_MED_FWD;
            state_next.delay_count = 8'd1;
            state_next.mode        = ST_RUN;
          end
        end
        default: ;
      endcase
    end
  end

  // result beat
  assign result.motor_update = upd;
  assign result.left_drive   = ld;
  assign result.right_drive  = rd;
  assign result.mode         = mode_code(state_next.mode);

endmodule

// ----- src/edge_avoid_seek_drive_controller_unit.sv -----
// top level of the edge avoid seek drive controller
// Each input beat is one timer tick (tick = 1) or a no-op beat (tick = 0), and every
// input beat yields exactly one result beat with the drive levels and the mode after the
// step. The block takes one beat per clock as long as results are taken: a beat lands in the
// input register, the step logic computes the next controller state and the result from it,
// and the result register holds the result for the output side. Configuration writes are
// always ready and should be issued only while no beat is in flight.
module edge_avoid_seek_drive_controller_unit
  import eas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  eas_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output eas_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data
);

  eas_cfg_t   cfg;
  eas_in_t    in_reg;
  logic       in_reg_valid;
  eas_state_t state;
  eas_state_t state_next;
  eas_out_t   result;
  logic       advance;

  // configuration registers
  eas_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // step logic
  eas_step u_step (
    .item       (in_reg),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // handshake flow
  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_reg_valid || advance;

  // control and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid      <= 1'b0;
      out_valid         <= 1'b0;
      state.mode        <= ST_IDLE;
      state.delay_count <= DELAY_COUNT_RST;
      state.start_count <= START_COUNT_RST;
    end else begin
      if (in_ready) begin
        in_reg_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= in_reg_valid;
      end
      if (in_reg_valid && advance) begin
        state <= state_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
    if (in_reg_valid && advance) begin
      out_data <= result;
    end
  end

endmodule

// ----- test/edge_avoid_seek_drive_controller_unit_test.sv -----
// testbench for the edge avoid seek drive controller, with a drive predictor and checker
`timescale 1ns / 100ps

module edge_avoid_seek_drive_controller_unit_test;
  import eas_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int LIMIT_NS    = 3_000_000;

  // tracks controller state, predicts each drive beat and checks the returned ones
  class drive_checker;
    eas_cfg_t   regs;
    logic [1:0] mode_now;
    logic [7:0] delay_cnt;
    logic [7:0] start_cnt;
    eas_out_t   pending_drives[$];
    int         bad_beats;

    function new();
      regs.edge_threshold   = EDGE_THRESHOLD_RST;
      regs.steer_min_diff   = STEER_MIN_DIFF_RST;
      regs.start_wait_ticks = START_WAIT_TICKS_RST;
      regs.backoff_ticks    = BACKOFF_TICKS_RST;
      mode_now  = MODE_IDLE;
      delay_cnt = DELAY_COUNT_RST;
      start_cnt = START_COUNT_RST;
      bad_beats = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
      case (idx)
        REG_EDGE_THRESHOLD:   regs.edge_threshold   = val;
        REG_STEER_MIN_DIFF:   regs.steer_min_diff   = val;
        REG_START_WAIT_TICKS: regs.start_wait_ticks = val;
        REG_BACKOFF_TICKS:    regs.backoff_ticks    = val;
        default: ;
      endcase
    endfunction

    // advance the controller by one input beat and return the drive beat it yields
    function eas_out_t next_drive(eas_in_t d);
      eas_out_t   r;
      logic       edge_hit;
      logic       toward_right;
      logic [7:0] gap;
      r = '0;
      if (d.tick) begin
        edge_hit = (d.line_left > regs.edge_threshold) ||
                   (d.line_center > regs.edge_threshold) ||
                   (d.line_right > regs.edge_threshold);
        if (edge_hit && (mode_now == MODE_RUN || mode_now == MODE_ATTACK)) begin
          mode_now  = MODE_BACKOFF;
          delay_cnt = regs.backoff_ticks;
        end
        case (mode_now)
          MODE_IDLE: begin
            start_cnt = start_cnt + 8'd1;
            if (start_cnt > regs.start_wait_ticks) begin
              start_cnt = 8'd0;
              mode_now  = MODE_RUN;
            end
          end
          MODE_RUN, MODE_ATTACK: begin
            delay_cnt = delay_cnt - 8'd1;
            if (delay_cnt == 8'd0) begin
              toward_right = d.range_front_right > d.range_front_left;
              gap = toward_right ? d.range_front_right - d.range_front_left
                                 : d.range_front_left - d.range_front_right;
              delay_cnt = 8'd1;
              r.motor_update = 1'b1;
              if (gap < regs.steer_min_diff) begin
                r.left_drive  = DRV_MED_FWD;
                r.right_drive = DRV_MED_FWD;
                mode_now = MODE_RUN;
              end else begin
                r.left_drive  = toward_right ? DRV_FAST_FWD : DRV_MED_FWD;
                r.right_drive = toward_right ? DRV_MED_FWD : DRV_FAST_FWD;
                mode_now = MODE_ATTACK;
              end
            end
          end
          default: begin
            // turn away on entry, resume run when the count runs out
            if (delay_cnt == regs.backoff_ticks) begin
              r.motor_update = 1'b1;
              if (d.line_right > regs.edge_threshold) begin
                r.left_drive  = DRV_MED_FWD;
                r.right_drive = DRV_MED_REV;
              end else begin
                r.left_drive  = DRV_MED_REV;
                r.right_drive = DRV_MED_FWD;
              end
            end
            delay_cnt = delay_cnt - 8'd1;
            if (delay_cnt == 8'd0) begin
              r.motor_update = 1'b1;
              r.left_drive   = DRV_MED_FWD;
              r.right_drive  = DRV_MED_FWD;
              delay_cnt = 8'd1;
              mode_now  = MODE_RUN;
            end
          end
        endcase
      end
      r.mode = mode_now;
      return r;
    endfunction

    function void note_tick_beat(eas_in_t d);
      pending_drives.push_back(next_drive(d));
    endfunction

    function void check_drive_beat(eas_out_t got);
      eas_out_t want;
      if (pending_drives.size() == 0) begin
        $display("%0t: drive beat %h arrived with nothing expected", $time, got);
        bad_beats++;
        return;
      end
      want = pending_drives.pop_front();
      if (got.motor_update !== want.motor_update) begin
        $display("%0t: motor_update expected %0d got %0d", $time, want.motor_update,
                 got.motor_update);
        bad_beats++;
      end
      if (got.left_drive !== want.left_drive) begin
        $display("%0t: left_drive expected %0d got %0d", $time, want.left_drive,
                 got.left_drive);
        bad_beats++;
      end
      if (got.right_drive !== want.right_drive) begin
        $display("%0t: right_drive expected %0d got %0d", $time, want.right_drive,
                 got.right_drive);
        bad_beats++;
      end
      if (got.mode !== want.mode) begin
        $display("%0t: mode expected %0d got %0d", $time, want.mode, got.mode);
        bad_beats++;
      end
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  eas_in_t            in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  eas_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  drive_checker sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  edge_avoid_seek_drive_controller_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result beat monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_drive_beat(out_data);
    end
  end

  // timeout
  initial begin
    #LIMIT_NS;
    $display("status: fail");
    $finish;
  end

  function automatic eas_in_t sensor_beat(logic t, logic [7:0] ll, logic [7:0] lc,
                                          logic [7:0] lr, logic [7:0] fl, logic [7:0] fr);
    eas_in_t d;
    d.tick              = t;
    d.line_left         = ll;
    d.line_center       = lc;
    d.line_right        = lr;
    d.range_front_left  = fl;
    d.range_front_right = fr;
    return d;
  endfunction

  // mostly quiet line samples so run and attack last, ranges near the steer minimum
  function automatic logic [7:0] line_sample();
    if ($urandom_range(99) < 8) begin
      return 8'($urandom_range(255));
    end
    return 8'($urandom_range(sb.regs.edge_threshold));
  endfunction

  function automatic eas_in_t random_beat();
    int fl;
    int fr;
    int off;
    fl = $urandom_range(255);
    if ($urandom_range(1) == 1) begin
      fr = $urandom_range(255);
    end else begin
      off = int'(sb.regs.steer_min_diff) + $urandom_range(2) - 1;
      fr  = ($urandom_range(1) == 1) ? fl + off : fl - off;
      fr  = (fr < 0) ? 0 : (fr > 255) ? 255 : fr;
    end
    return sensor_beat($urandom_range(99) < 85, line_sample(), line_sample(),
                       line_sample(), 8'(fl), 8'(fr));
  endfunction

  // offer one input beat, idling first at the current sender rate
  task automatic push_beat(input eas_in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_tick_beat(d);
  endtask

  task automatic push_random(input int n, input logic force_tick);
    eas_in_t d;
    for (int k = 0; k < n; k++) begin
      d = random_beat();
      if (force_tick) begin
        d.tick = 1'b1;
      end
      push_beat(d);
    end
  endtask

  // stop sending and wait until every expected drive beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // write all four registers, then one index past the list that must be ignored
  task automatic program_regs(input logic [7:0] thr, input logic [7:0] steer,
                              input logic [7:0] wait_ticks, input logic [7:0] boff);
    logic [CfgIdxW-1:0] idx[5];
    logic [7:0]         val[5];
    idx = '{REG_EDGE_THRESHOLD, REG_STEER_MIN_DIFF, REG_START_WAIT_TICKS,
            REG_BACKOFF_TICKS, CfgIdxW'($urandom_range(4, 255))};
    val = '{thr, steer, wait_ticks, boff, 8'($urandom_range(255))};
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] thr, input logic [7:0] steer,
                           input logic [7:0] wait_ticks, input logic [7:0] boff,
                           input int snd, input int rcv, input int n);
    drain();
    program_regs(thr, steer, wait_ticks, boff);
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
    push_random(n, 1'b0);
  endtask

  initial begin
    int snd_opts[4];
    int rcv_opts[4];
    int pick;
    snd_opts = '{0, 88, 0, 11};
    rcv_opts = '{0, 0, 88, 11};
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // idle: no tick, and a tick with every sample high that must not leave idle
    push_beat(sensor_beat(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_beat(sensor_beat(1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    // start wait of 255: the idle count wraps and idle never ends
    drain();
    program_regs(EDGE_THRESHOLD_RST, STEER_MIN_DIFF_RST, 8'd255, 8'd3);
    push_random(258, 1'b1);
    drain();
    program_regs(EDGE_THRESHOLD_RST, STEER_MIN_DIFF_RST, 8'd254, 8'd3);
    push_random(3, 1'b1);
    drain();
    program_regs(EDGE_THRESHOLD_RST, STEER_MIN_DIFF_RST, 8'd0, 8'd3);
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    // run: count down from the reset delay with quiet lines
    for (int k = 0; k < 9; k++) begin
      push_beat(sensor_beat(1'b1, 8'($urandom_range(48)), 8'($urandom_range(48)),
                            8'($urandom_range(48)), 8'($urandom_range(255)),
                            8'($urandom_range(255))));
    end

    // steering around the minimum difference and at the range extremes
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd10, 8'd14));
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd14, 8'd10));
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd10, 8'd13));
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd200, 8'd200));
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd0, 8'd255));
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd255, 8'd0));
    push_beat(sensor_beat(1'b0, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));

    // edge on the left line turns one way, edge during backoff is ignored
    push_beat(sensor_beat(1'b1, 8'd49, 8'h00, 8'h00, 8'd20, 8'd90));
    push_beat(sensor_beat(1'b1, 8'hff, 8'hff, 8'hff, 8'd20, 8'd90));
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd20, 8'd90));
    // a line level equal to the threshold is no edge
    push_beat(sensor_beat(1'b1, 8'd48, 8'd48, 8'd48, 8'd90, 8'd20));
    // edge on the right line turns the other way
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'hff, 8'd0, 8'd0));
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0));
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0));

    // steer minimum of 0: always steers, equal readings count as left
    drain();
    program_regs(EDGE_THRESHOLD_RST, 8'd0, 8'd0, 8'd3);
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd77, 8'd77));
    push_beat(sensor_beat(1'b1, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0));

    // random phases over several settings and idling patterns
    run_phase(8'd48, 8'd4, 8'd17, 8'd5, 0, 0, 200);
    run_phase(8'd255, 8'd0, 8'd254, 8'd1, 88, 0, 120);
    run_phase(8'd0, 8'd255, 8'd255, 8'd255, 0, 88, 120);
    // backoff ticks of 0 give a 256 tick turn
    run_phase(8'd100, 8'd10, 8'd0, 8'd0, 11, 11, 200);

    // long receiver hold-off while beats keep coming, so the input stalls
    drain();
    program_regs(8'd60, 8'd8, 8'd3, 8'd4);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = hold_requests + 1;
    push_random(40, 1'b0);

    for (int p = 0; p < 6; p++) begin
      pick = $urandom_range(3);
      run_phase(8'($urandom_range(20, 200)), 8'($urandom_range(40)),
                8'($urandom_range(255)), 8'($urandom_range(1, 12)),
                snd_opts[pick], rcv_opts[pick], 50);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.bad_beats == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
